FILE: rtl/core/frame_change_tick_counter_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the frame change tick counter core
// Concurrent checks that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef FRAME_CHANGE_TICK_COUNTER_CORE_DEFINES_SVH
`define FRAME_CHANGE_TICK_COUNTER_CORE_DEFINES_SVH

`ifndef SYNTH
// check held outside reset
`define FCTC_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
	else $error("assertion failed: lbl");
// check held on every edge, reset included
`define FCTC_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) (prop)) \
	else $error("assertion failed: lbl");
`else
`define FCTC_ASSERT(lbl, clk, rst_n, prop)
`define FCTC_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

FILE: rtl/core/fctc_pkg.sv
// ----------------------------------------------------------------------------
// fctc_pkg
// Shared sizes, register codes and word types of the tick counter core.
// ----------------------------------------------------------------------------
package fctc_pkg;

	localparam int FRAME_SLOTS   = 20;
	localparam int WINDOW_PIXELS = 1024;

	localparam int SLOT_W = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;
	localparam int IDX_W  = (WINDOW_PIXELS > 1) ? $clog2(WINDOW_PIXELS) : 1;
	localparam int ADDR_W = $clog2(FRAME_SLOTS * WINDOW_PIXELS);

	localparam int PIX_W = 8;
	localparam int SUM_W = 24;
	localparam int RUN_W = 8;
	localparam int CNT_W = 32;

	// pixel queue between front and back
	localparam int PQ_DEPTH = 4;
	localparam int PQ_PTR_W = $clog2(PQ_DEPTH);
	localparam int PQ_LVL_W = $clog2(PQ_DEPTH + 1);

	// result queue
	localparam int RES_DEPTH = 2;
	localparam int RES_PTR_W = 1;
	localparam int RES_LVL_W = 2;

	// configuration port
	localparam int CFG_ADDR_W = 4;
	localparam int CFG_DATA_W = 32;

	localparam logic [7:0]       THRESHOLD_RST = 8'd40;
	localparam logic [SUM_W-1:0] TRIGGER_RST   = 24'd300;
	localparam logic [RUN_W-1:0] LIMIT_RST     = 8'd7;
	localparam logic             COUNT_UP_RST  = 1'b1;

	typedef enum logic [1:0] {
		REG_PIXEL_THRESHOLD = 2'd0,
		REG_FRAME_TRIGGER   = 2'd1,
		REG_GLITCH_LIMIT    = 2'd2,
		REG_COUNT_UP        = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [7:0]       pixel_threshold;
		logic [SUM_W-1:0] frame_trigger;
		logic [RUN_W-1:0] glitch_limit;
		logic             count_up;
	} cfg_t;

	// ring pointers from back to front, with the end-of-frame pulse
	typedef struct packed {
		logic [SLOT_W-1:0] head;
		logic [SLOT_W-1:0] tail;
		logic              frame_done;
	} ring_t;

	typedef struct packed {
		logic [PIX_W-1:0] gray;
		logic [PIX_W-1:0] old;
		logic             cmp;
		logic             last;
	} pix_word_t;

	typedef struct packed {
		logic [CNT_W-1:0] count_value;
		logic [SUM_W-1:0] frame_change;
		logic             stepped;
	} res_word_t;

endpackage

FILE: rtl/core/frame_change_tick_counter_core.sv
// ----------------------------------------------------------------------------
// frame_change_tick_counter_core
// Watches a fixed pixel window frame by frame and counts ticks of a counter
// seen there. Push one RGB pixel per word, last_in_frame on the final pixel;
// one result word (running count, the frame's summed change, step flag) comes
// out per frame. Inside a frame a pixel is taken every cycle: the front turns
// it to gray and does one write and one read of the frame ring memory in the
// same cycle. After the last pixel of a frame, full stays high while the back
// sums the last difference and judges the frame, because the next frame's
// compare slot depends on that judgment; it stays high longer if the result
// queue (two words) is not drained. Registers (APB, byte address 4*i): pixel
// threshold, frame trigger, glitch limit, count direction; write them only
// while the block is idle. The frame ring memory is not cleared at reset;
// compares start once a frame is stored.
// ----------------------------------------------------------------------------
module frame_change_tick_counter_core import fctc_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	// configuration
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [CFG_ADDR_W-1:0]   paddr,
	input  logic [CFG_DATA_W-1:0]   pwdata,
	output logic [CFG_DATA_W-1:0]   prdata,
	output logic                    pready,
	// pixel words
	input  logic                    push,
	output logic                    full,
	input  logic [PIX_W-1:0]        red,
	input  logic [PIX_W-1:0]        green,
	input  logic [PIX_W-1:0]        blue,
	input  logic                    last_in_frame,
	// result words
	output logic                    empty,
	input  logic                    pop,
	output logic signed [CNT_W-1:0] count_value,
	output logic [SUM_W-1:0]        frame_change,
	output logic                    stepped
);

	cfg_t          cfg_q;
	reg_idx_t      reg_idx;
	logic          cfg_wr;

	ring_t         ring;
	logic          pq_push;
	pix_word_t     pq_wdata;
	logic          pq_pop;
	logic          pq_valid;
	pix_word_t     pq_rdata;
	logic [PQ_LVL_W-1:0] pq_level;
	res_word_t     res_word;

	// --- configuration registers ---
	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pixel_threshold <= THRESHOLD_RST;
			cfg_q.frame_trigger   <= TRIGGER_RST;
			cfg_q.glitch_limit    <= LIMIT_RST;
			cfg_q.count_up        <= COUNT_UP_RST;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_PIXEL_THRESHOLD: cfg_q.pixel_threshold <= pwdata[7:0];
				REG_FRAME_TRIGGER:   cfg_q.frame_trigger   <= pwdata[SUM_W-1:0];
				REG_GLITCH_LIMIT:    cfg_q.glitch_limit    <= pwdata[RUN_W-1:0];
				REG_COUNT_UP:        cfg_q.count_up        <= pwdata[0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_PIXEL_THRESHOLD: prdata = CFG_DATA_W'(cfg_q.pixel_threshold);
			REG_FRAME_TRIGGER:   prdata = CFG_DATA_W'(cfg_q.frame_trigger);
			REG_GLITCH_LIMIT:    prdata = CFG_DATA_W'(cfg_q.glitch_limit);
			REG_COUNT_UP:        prdata = CFG_DATA_W'(cfg_q.count_up);
			default:             prdata = '0;
		endcase
	end

	// --- front: gray conversion and ring memory access ---
	fctc_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.red           (red),
		.green         (green),
		.blue          (blue),
		.last_in_frame (last_in_frame),
		.ring          (ring),
		.pq_level      (pq_level),
		.pq_push       (pq_push),
		.pq_wdata      (pq_wdata)
	);

	// --- decoupling queue ---
	fctc_pix_queue u_pix_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (pq_push),
		.wdata  (pq_wdata),
		.pop    (pq_pop),
		.valid  (pq_valid),
		.rdata  (pq_rdata),
		.level  (pq_level)
	);

	// --- back: change sum, frame judgment, ring pointers, result queue ---
	fctc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pq_valid  (pq_valid),
		.pq_rdata  (pq_rdata),
		.pq_pop    (pq_pop),
		.ring      (ring),
		.res_empty (empty),
		.res_pop   (pop),
		.res_word  (res_word)
	);

	assign count_value  = signed'(res_word.count_value);
	assign frame_change = res_word.frame_change;
	assign stepped      = res_word.stepped;

endmodule

FILE: rtl/core/fctc_front.sv
// ----------------------------------------------------------------------------
// fctc_front
// Takes pixels, converts to gray, writes the head frame and reads the tail.
// ----------------------------------------------------------------------------
`include "frame_change_tick_counter_core_defines.svh"

module fctc_front import fctc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic [PIX_W-1:0]    red,
	input  logic [PIX_W-1:0]    green,
	input  logic [PIX_W-1:0]    blue,
	input  logic                last_in_frame,
	input  ring_t               ring,
	input  logic [PQ_LVL_W-1:0] pq_level,
	output logic                pq_push,
	output pix_word_t           pq_wdata
);

	// (r+g+b)/3 as (s*683)>>11, exact for s <= 765
	function automatic logic [PIX_W-1:0] gray_of(input logic [PIX_W-1:0] r,
		input logic [PIX_W-1:0] g, input logic [PIX_W-1:0] b);
		logic [9:0]  s;
		logic [19:0] p;
		s = {2'b00, r} + {2'b00, g} + {2'b00, b};
		p = {10'd0, s} * 20'd683;
		return p[18:11];
	endfunction

	logic [PIX_W-1:0]    frame_store [FRAME_SLOTS*WINDOW_PIXELS];
	logic [IDX_W-1:0]    pix_idx_q;
	logic                wait_q;
	logic                accept;
	logic [PIX_W-1:0]    gray;
	logic [ADDR_W-1:0]   wr_addr;
	logic [ADDR_W-1:0]   rd_addr;
	logic [PQ_LVL_W-1:0] occupied;

	logic                valid_s1;
	logic [PIX_W-1:0]    gray_s1;
	logic [PIX_W-1:0]    old_s1;
	logic                cmp_s1;
	logic                last_s1;

	// credit: every accepted pixel has a queue slot waiting for it
	assign occupied = pq_level + PQ_LVL_W'(valid_s1);
	assign full     = wait_q || (occupied >= PQ_LVL_W'(PQ_DEPTH));
	assign accept   = push && !full;
	assign gray     = gray_of(red, green, blue);
	assign wr_addr  = ADDR_W'(ring.head) * ADDR_W'(WINDOW_PIXELS) + ADDR_W'(pix_idx_q);
	assign rd_addr  = ADDR_W'(ring.tail) * ADDR_W'(WINDOW_PIXELS) + ADDR_W'(pix_idx_q);

	always_ff @(posedge clk) begin
		if (accept) begin
			frame_store[wr_addr] <= gray;
			old_s1               <= frame_store[rd_addr];
			gray_s1              <= gray;
			cmp_s1               <= (ring.tail != ring.head);
			last_s1              <= last_in_frame;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			wait_q    <= 1'b0;
			pix_idx_q <= '0;
		end else begin
			valid_s1 <= accept;
			if (accept && last_in_frame) begin
				wait_q <= 1'b1;
			end else if (ring.frame_done) begin
				wait_q <= 1'b0;
			end
			if (accept) begin
				if (last_in_frame || (pix_idx_q == IDX_W'(WINDOW_PIXELS - 1))) begin
					pix_idx_q <= '0;
				end else begin
					pix_idx_q <= pix_idx_q + 1'b1;
				end
			end
		end
	end

	assign pq_push       = valid_s1;
	assign pq_wdata.gray = gray_s1;
	assign pq_wdata.old  = old_s1;
	assign pq_wdata.cmp  = cmp_s1;
	assign pq_wdata.last = last_s1;

	// a frame end in flight keeps the input closed until the ring moves
	`FCTC_ASSERT(a_last_holds_input, clk, arst_n, valid_s1 && last_s1 |-> wait_q)

endmodule

FILE: rtl/core/fctc_pix_queue.sv
// ----------------------------------------------------------------------------
// fctc_pix_queue
// Short first-word-fall-through queue of gray/old pixel pairs.
// ----------------------------------------------------------------------------
`include "frame_change_tick_counter_core_defines.svh"

module fctc_pix_queue import fctc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  pix_word_t           wdata,
	input  logic                pop,
	output logic                valid,
	output pix_word_t           rdata,
	output logic [PQ_LVL_W-1:0] level
);

	pix_word_t           slots_q [PQ_DEPTH];
	logic [PQ_PTR_W-1:0] wr_ptr_q;
	logic [PQ_PTR_W-1:0] rd_ptr_q;
	logic [PQ_LVL_W-1:0] cnt_q;
	logic                do_pop;

	assign valid  = (cnt_q != '0);
	assign rdata  = slots_q[rd_ptr_q];
	assign level  = cnt_q;
	assign do_pop = pop && valid;

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + PQ_LVL_W'(push) - PQ_LVL_W'(do_pop);
		end
	end

	// the front's credit check must never let a push land on a full queue
	`FCTC_ASSERT(a_pq_no_overflow, clk, arst_n, push |-> cnt_q < PQ_LVL_W'(PQ_DEPTH))

endmodule

FILE: rtl/core/fctc_back.sv
// ----------------------------------------------------------------------------
// fctc_back
// Sums pixel changes, judges each frame, moves the ring, queues results.
// ----------------------------------------------------------------------------
`include "frame_change_tick_counter_core_defines.svh"

module fctc_back import fctc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      pq_valid,
	input  pix_word_t pq_rdata,
	output logic      pq_pop,
	output ring_t     ring,
	output logic      res_empty,
	input  logic      res_pop,
	output res_word_t res_word
);

	function automatic logic [SLOT_W-1:0] slot_next(input logic [SLOT_W-1:0] s);
		return (s == SLOT_W'(FRAME_SLOTS - 1)) ? '0 : s + 1'b1;
	endfunction

	function automatic logic [SLOT_W-1:0] slot_prev(input logic [SLOT_W-1:0] s);
		return (s == '0) ? SLOT_W'(FRAME_SLOTS - 1) : s - 1'b1;
	endfunction

	logic [SUM_W-1:0]     sum_q;
	logic [SLOT_W-1:0]    head_q;
	logic [SLOT_W-1:0]    tail_q;
	logic [RUN_W-1:0]     run_q;
	logic [CNT_W-1:0]     tick_q;

	logic                 judge_s2;
	logic [SUM_W-1:0]     fsum_s2;

	res_word_t            res_q [RES_DEPTH];
	logic [RES_PTR_W-1:0] res_wr_q;
	logic [RES_PTR_W-1:0] res_rd_q;
	logic [RES_LVL_W-1:0] res_cnt_q;

	logic                 res_room;
	logic [PIX_W-1:0]     diff;
	logic                 hit;
	logic [SUM_W:0]       sum_add;
	logic [SUM_W-1:0]     sum_new;

	logic                 over;
	logic [RUN_W-1:0]     run_inc;
	logic                 step_now;
	logic [SLOT_W-1:0]    tail_new;
	logic [RUN_W-1:0]     run_new;
	logic [CNT_W-1:0]     tick_new;
	logic                 res_do_pop;

	// pixel stage
	assign res_room = (res_cnt_q + RES_LVL_W'(judge_s2)) < RES_LVL_W'(RES_DEPTH);
	assign pq_pop   = pq_valid && (!pq_rdata.last || res_room);
	assign diff     = (pq_rdata.old > pq_rdata.gray) ? pq_rdata.old - pq_rdata.gray
	                                                 : pq_rdata.gray - pq_rdata.old;
	assign hit      = pq_rdata.cmp && (diff > cfg.pixel_threshold);
	assign sum_add  = {1'b0, sum_q} + (SUM_W + 1)'(diff);
	assign sum_new  = !hit ? sum_q : (sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0]);

	// frame judgment
	always_comb begin
		over     = (fsum_s2 > cfg.frame_trigger);
		run_inc  = run_q + 1'b1;
		step_now = over && (run_inc == cfg.glitch_limit);
		tick_new = tick_q;
		if (over) begin
			if (step_now) begin
				tick_new = cfg.count_up ? tick_q + 1'b1 : tick_q - 1'b1;
				run_new  = '0;
				tail_new = head_q;
			end else begin
				run_new  = run_inc;
				// advance then step back
				tail_new = (tail_q != head_q) ? tail_q : slot_prev(tail_q);
			end
		end else begin
			run_new = '0;
			if (run_q != '0) begin
				tail_new = head_q;
			end else begin
				tail_new = (tail_q != head_q) ? slot_next(tail_q) : tail_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pq_pop && pq_rdata.last) begin
			fsum_s2 <= sum_new;
		end
		if (judge_s2) begin
			res_q[res_wr_q] <= '{count_value: tick_new, frame_change: fsum_s2,
			                     stepped: step_now};
		end
	end

	assign res_do_pop = res_pop && (res_cnt_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q     <= '0;
			judge_s2  <= 1'b0;
			head_q    <= '0;
			tail_q    <= '0;
			run_q     <= '0;
			tick_q    <= '0;
			res_wr_q  <= '0;
			res_rd_q  <= '0;
			res_cnt_q <= '0;
		end else begin
			if (pq_pop) begin
				sum_q <= pq_rdata.last ? '0 : sum_new;
			end
			judge_s2 <= pq_pop && pq_rdata.last;
			if (judge_s2) begin
				head_q   <= slot_next(head_q);
				tail_q   <= tail_new;
				run_q    <= run_new;
				tick_q   <= tick_new;
				res_wr_q <= res_wr_q + 1'b1;
			end
			if (res_do_pop) begin
				res_rd_q <= res_rd_q + 1'b1;
			end
			res_cnt_q <= res_cnt_q + RES_LVL_W'(judge_s2) - RES_LVL_W'(res_do_pop);
		end
	end

	assign ring.head       = head_q;
	assign ring.tail       = tail_q;
	assign ring.frame_done = judge_s2;
	assign res_empty       = (res_cnt_q == '0);
	assign res_word        = res_q[res_rd_q];

	`FCTC_ASSERT_ALWAYS(a_res_bounded, clk, !arst_n || (res_cnt_q <= RES_LVL_W'(RES_DEPTH)))
	`FCTC_ASSERT(a_judge_has_room, clk, arst_n, judge_s2 |-> res_cnt_q < RES_LVL_W'(RES_DEPTH))
	`FCTC_ASSERT(a_step_opens_ring, clk, arst_n, judge_s2 && step_now |=> tail_q != head_q)

endmodule
